// ----- src/kacc_pkg.sv -----
// Shared types and constants for the keypad alarm clock controller.
// Has no dependencies; the top level uses it.
package kacc_pkg;

   localparam logic [15:0] TENTHS_PER_HOUR = 16'd36000;
   localparam logic [4:0]  HOURS_PER_DAY   = 5'd24;
   localparam logic [15:0] BEEP_TENTHS     = 16'd5;

   localparam logic [3:0] KEY_A = 4'd10;
   localparam logic [3:0] KEY_B = 4'd11;
   localparam logic [3:0] KEY_C = 4'd12;
   localparam logic [3:0] KEY_D = 4'd13;
   localparam logic [3:0] KEY_E = 4'd14;
   localparam logic [3:0] KEY_F = 4'd15;

   localparam logic [1:0] BUF_CLOCK = 2'd0;
   localparam logic [1:0] BUF_ALARM = 2'd1;
   localparam logic [1:0] BUF_TIMER = 2'd2;

   typedef enum logic [2:0] {
      MODE_SET_CLOCK = 3'd0,
      MODE_CLOCK     = 3'd1,
      MODE_MENU      = 3'd2,
      MODE_SET_ALARM = 3'd3,
      MODE_SET_TIMER = 3'd4,
      MODE_WATCH     = 3'd5
   } mode_type;

   // Keypad position to key code, layout 1 2 3 A / 4 5 6 B / 7 8 9 C / E 0 F D.
   function automatic logic [3:0] key_code(input logic [3:0] index);
      logic [3:0] code;
      unique case (index)
         4'd0:    code = 4'd1;
         4'd1:    code = 4'd2;
         4'd2:    code = 4'd3;
         4'd3:    code = KEY_A;
         4'd4:    code = 4'd4;
         4'd5:    code = 4'd5;
         4'd6:    code = 4'd6;
         4'd7:    code = KEY_B;
         4'd8:    code = 4'd7;
         4'd9:    code = 4'd8;
         4'd10:   code = 4'd9;
         4'd11:   code = KEY_C;
         4'd12:   code = KEY_E;
         4'd13:   code = 4'd0;
         4'd14:   code = KEY_F;
         default: code = KEY_D;
      endcase
      return code;
   endfunction

endpackage

// ----- src/kacc_channels.sv -----
// Valid/ready channel interfaces for requests and responses.
// Depends on nothing; used by the top level.
interface kacc_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [3:0] key_index;
   modport source (output valid, output req_type, output key_index, input ready);
   modport sink (input valid, input req_type, input key_index, output ready);
endinterface

interface kacc_rsp_if;
   logic        valid;
   logic        ready;
   logic        buzzer;
   logic [2:0]  mode;
   logic [4:0]  hours_now;
   logic [15:0] tenths_in_hour;
   logic [4:0]  watch_hours;
   logic [15:0] watch_tenths;
   logic        alarm_sounding;
   logic        timer_sounding;
   logic        watch_running;
   logic        key_rejected;
   modport source (output valid, output buzzer, output mode, output hours_now,
                   output tenths_in_hour, output watch_hours, output watch_tenths,
                   output alarm_sounding, output timer_sounding,
                   output watch_running, output key_rejected, input ready);
   modport sink (input valid, input buzzer, input mode, input hours_now,
                 input tenths_in_hour, input watch_hours, input watch_tenths,
                 input alarm_sounding, input timer_sounding,
                 input watch_running, input key_rejected, output ready);
endinterface

// ----- src/keypad_alarm_clock_controller.sv -----
// The state registers are updated when a request transaction is accepted and
// double as the response register, so a new transaction is taken
// in every cycle in which the pending response is taken or none is pending.
// Depends on kacc_pkg and the channel interfaces in kacc_channels.sv.
module keypad_alarm_clock_controller (
   input  logic          clock,
   input  logic          reset,
   kacc_req_if.sink      req_if,
   kacc_rsp_if.source    rsp_if
);

   logic [4:0]  clock_hours_ff, clock_hours_in;
   logic [15:0] clock_tenths_ff, clock_tenths_in;
   logic [2:0]  mod5_ff, mod5_in;
   logic [1:0]  mod3_ff, mod3_in;
   logic [4:0]  alarm_hours_ff, alarm_hours_in;
   logic [15:0] alarm_tenths_ff, alarm_tenths_in;
   logic [4:0]  timer_hours_ff, timer_hours_in;
   logic [15:0] timer_tenths_ff, timer_tenths_in;
   logic [4:0]  watch_hours_ff, watch_hours_in;
   logic [15:0] watch_tenths_ff, watch_tenths_in;
   logic [16:0] beep_end_ff, beep_end_in;
   logic        alarm_ff, alarm_in;
   logic        timer_ff, timer_in;
   logic        run_ff, run_in;
   logic        buzz_ff, buzz_in;
   kacc_pkg::mode_type mode_ff, mode_in;
   logic [3:0]  digits_ff [3][4];
   logic [1:0]  pos_ff [3];
   logic [1:0]  pos_in [3];
   logic        rejected_ff, rejected_in;
   logic        rsp_valid_ff;

   logic        accept;
   logic        entry_write;
   logic [1:0]  entry_buf;
   logic [1:0]  entry_pos;
   logic [3:0]  code;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept = req_if.valid && req_if.ready;
   assign code = kacc_pkg::key_code(req_if.key_index);

   always_comb begin
      logic        entry;
      logic        check;
      logic        bad;
      logic        done;
      logic [3:0]  d0;
      logic [3:0]  d1;
      logic [3:0]  d2;
      logic [6:0]  hi;
      logic [6:0]  lo;
      logic [16:0] ds;
      logic [4:0]  hsum;
      logic [15:0] bsum;
      clock_hours_in  = clock_hours_ff;
      clock_tenths_in = clock_tenths_ff;
      mod5_in         = mod5_ff;
      mod3_in         = mod3_ff;
      alarm_hours_in  = alarm_hours_ff;
      alarm_tenths_in = alarm_tenths_ff;
      timer_hours_in  = timer_hours_ff;
      timer_tenths_in = timer_tenths_ff;
      watch_hours_in  = watch_hours_ff;
      watch_tenths_in = watch_tenths_ff;
      beep_end_in     = beep_end_ff;
      alarm_in        = alarm_ff;
      timer_in        = timer_ff;
      run_in          = run_ff;
      buzz_in         = buzz_ff;
      mode_in         = mode_ff;
      pos_in          = pos_ff;
      rejected_in     = rejected_ff;
      entry_write     = 1'b0;
      entry           = 1'b0;
      check           = 1'b1;
      bad             = 1'b0;
      done            = 1'b0;
      entry_buf       = kacc_pkg::BUF_CLOCK;
      entry_pos       = 2'd0;
      d0 = 4'd0; d1 = 4'd0; d2 = 4'd0;
      hi = 7'd0; lo = 7'd0; ds = 17'd0; hsum = 5'd0; bsum = 16'd0;
      if (accept) begin
         rejected_in = 1'b0;
         if (!req_if.req_type) begin
            if (clock_tenths_ff == kacc_pkg::TENTHS_PER_HOUR - 16'd1) begin
               clock_tenths_in = 16'd0;
               mod5_in = 3'd0;
               mod3_in = 2'd0;
               clock_hours_in = (clock_hours_ff == kacc_pkg::HOURS_PER_DAY - 5'd1) ?
                                5'd0 : clock_hours_ff + 5'd1;
            end else begin
               clock_tenths_in = clock_tenths_ff + 16'd1;
               mod5_in = (mod5_ff == 3'd4) ? 3'd0 : mod5_ff + 3'd1;
               mod3_in = (mod3_ff == 2'd2) ? 2'd0 : mod3_ff + 2'd1;
            end
            if (run_ff) begin
               if (watch_tenths_ff == kacc_pkg::TENTHS_PER_HOUR - 16'd1) begin
                  watch_tenths_in = 16'd0;
                  watch_hours_in = (watch_hours_ff == kacc_pkg::HOURS_PER_DAY - 5'd1) ?
                                   5'd0 : watch_hours_ff + 5'd1;
               end else begin
                  watch_tenths_in = watch_tenths_ff + 16'd1;
               end
            end
            if ({1'b0, clock_tenths_in} == beep_end_ff) begin
               beep_end_in = {1'b0, kacc_pkg::TENTHS_PER_HOUR};
               buzz_in = 1'b0;
            end
            if (clock_hours_in == alarm_hours_ff && clock_tenths_in == alarm_tenths_ff) begin
               alarm_in = 1'b1;
            end
            if (clock_hours_in == timer_hours_ff && clock_tenths_in == timer_tenths_ff) begin
               timer_in = 1'b1;
               timer_hours_in = kacc_pkg::HOURS_PER_DAY;
            end
            if (alarm_in && mod5_in == 3'd0) begin
               buzz_in = !buzz_in;
            end
            if (timer_in && mod3_in != 2'd0) begin
               buzz_in = !buzz_in;
            end
         end else if (code == kacc_pkg::KEY_E) begin
            mode_in = kacc_pkg::MODE_CLOCK;
         end else if (code == kacc_pkg::KEY_F) begin
            alarm_in = 1'b0;
            timer_in = 1'b0;
            buzz_in = 1'b0;
         end else begin
            unique case (mode_ff)
               kacc_pkg::MODE_SET_CLOCK: begin
                  entry = 1'b1;
                  entry_buf = kacc_pkg::BUF_CLOCK;
               end
               kacc_pkg::MODE_CLOCK: begin
                  if (code == 4'd0) mode_in = kacc_pkg::MODE_MENU;
                  else bad = 1'b1;
               end
               kacc_pkg::MODE_MENU: begin
                  if (code == kacc_pkg::KEY_A) begin
                     mode_in = kacc_pkg::MODE_SET_ALARM;
                     pos_in[kacc_pkg::BUF_ALARM] = 2'd0;
                  end else if (code == kacc_pkg::KEY_B) begin
                     mode_in = kacc_pkg::MODE_SET_TIMER;
                  end else if (code == kacc_pkg::KEY_C) begin
                     mode_in = kacc_pkg::MODE_WATCH;
                  end else begin
                     bad = 1'b1;
                  end
               end
               kacc_pkg::MODE_SET_ALARM: begin
                  entry = 1'b1;
                  entry_buf = kacc_pkg::BUF_ALARM;
               end
               kacc_pkg::MODE_SET_TIMER: begin
                  entry = 1'b1;
                  check = 1'b0;
                  entry_buf = kacc_pkg::BUF_TIMER;
               end
               kacc_pkg::MODE_WATCH: begin
                  if (code == 4'd1) run_in = 1'b1;
                  else if (code == 4'd2) run_in = 1'b0;
                  else if (code == 4'd3) begin
                     watch_hours_in = 5'd0;
                     watch_tenths_in = 16'd0;
                  end else bad = 1'b1;
               end
               default: bad = 1'b1;
            endcase
            if (entry) begin
               entry_pos = pos_ff[entry_buf];
               d0 = digits_ff[entry_buf][0];
               d1 = digits_ff[entry_buf][1];
               d2 = digits_ff[entry_buf][2];
               if (code > 4'd9) begin
                  bad = 1'b1;
               end else if (check && ((entry_pos == 2'd0 && code > 4'd2) ||
                            (entry_pos == 2'd1 && d0 == 4'd2 && code > 4'd3) ||
                            (entry_pos == 2'd2 && code > 4'd5))) begin
                  bad = 1'b1;
               end else begin
                  entry_write = 1'b1;
                  if (entry_pos == 2'd3) begin
                     pos_in[entry_buf] = 2'd0;
                     done = 1'b1;
                  end else begin
                     pos_in[entry_buf] = entry_pos + 2'd1;
                  end
               end
               hi = 7'(d0) * 7'd10 + 7'(d1);
               lo = 7'(d2) * 7'd10 + 7'(code);
               if (done) begin
                  if (entry_buf == kacc_pkg::BUF_TIMER) begin
                     ds = 17'(clock_tenths_ff) + 17'(hi) * 17'd600 + 17'(lo) * 17'd10;
                     hsum = clock_hours_ff;
                     if (ds >= 17'd72000) begin
                        ds = ds - 17'd72000;
                        hsum = hsum + 5'd2;
                     end else if (ds >= 17'd36000) begin
                        ds = ds - 17'd36000;
                        hsum = hsum + 5'd1;
                     end
                     if (hsum >= kacc_pkg::HOURS_PER_DAY) begin
                        hsum = hsum - kacc_pkg::HOURS_PER_DAY;
                     end
                     timer_hours_in = hsum;
                     timer_tenths_in = ds[15:0];
                  end else if (entry_buf == kacc_pkg::BUF_ALARM) begin
                     alarm_hours_in = hi[4:0];
                     alarm_tenths_in = 16'(lo) * 16'd600;
                     mode_in = kacc_pkg::MODE_CLOCK;
                  end else begin
                     clock_hours_in = hi[4:0];
                     clock_tenths_in = 16'(lo) * 16'd600;
                     mod5_in = 3'd0;
                     mod3_in = 2'd0;
                     mode_in = kacc_pkg::MODE_CLOCK;
                  end
               end
            end
            if (bad) begin
               bsum = clock_tenths_ff + kacc_pkg::BEEP_TENTHS;
               if (bsum >= kacc_pkg::TENTHS_PER_HOUR) begin
                  bsum = bsum - kacc_pkg::TENTHS_PER_HOUR;
               end
               beep_end_in = {1'b0, bsum};
               buzz_in = 1'b1;
            end
            rejected_in = bad;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_hours_ff  <= 5'd0;
         clock_tenths_ff <= 16'd0;
         mod5_ff         <= 3'd0;
         mod3_ff         <= 2'd0;
         alarm_hours_ff  <= kacc_pkg::HOURS_PER_DAY;
         alarm_tenths_ff <= 16'd0;
         timer_hours_ff  <= kacc_pkg::HOURS_PER_DAY;
         timer_tenths_ff <= 16'd0;
         watch_hours_ff  <= 5'd0;
         watch_tenths_ff <= 16'd0;
         beep_end_ff     <= {1'b0, kacc_pkg::TENTHS_PER_HOUR};
         alarm_ff        <= 1'b0;
         timer_ff        <= 1'b0;
         run_ff          <= 1'b0;
         buzz_ff         <= 1'b0;
         mode_ff         <= kacc_pkg::MODE_SET_CLOCK;
         pos_ff          <= '{2'd0, 2'd0, 2'd0};
         rejected_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         clock_hours_ff  <= clock_hours_in;
         clock_tenths_ff <= clock_tenths_in;
         mod5_ff         <= mod5_in;
         mod3_ff         <= mod3_in;
         alarm_hours_ff  <= alarm_hours_in;
         alarm_tenths_ff <= alarm_tenths_in;
         timer_hours_ff  <= timer_hours_in;
         timer_tenths_ff <= timer_tenths_in;
         watch_hours_ff  <= watch_hours_in;
         watch_tenths_ff <= watch_tenths_in;
         beep_end_ff     <= beep_end_in;
         alarm_ff        <= alarm_in;
         timer_ff        <= timer_in;
         run_ff          <= run_in;
         buzz_ff         <= buzz_in;
         mode_ff         <= mode_in;
         pos_ff          <= pos_in;
         rejected_ff     <= rejected_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (entry_write) begin
         digits_ff[entry_buf][entry_pos] <= code;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.buzzer         = buzz_ff;
   assign rsp_if.mode           = mode_ff;
   assign rsp_if.hours_now      = clock_hours_ff;
   assign rsp_if.tenths_in_hour = clock_tenths_ff;
   assign rsp_if.watch_hours    = watch_hours_ff;
   assign rsp_if.watch_tenths   = watch_tenths_ff;
   assign rsp_if.alarm_sounding = alarm_ff;
   assign rsp_if.timer_sounding = timer_ff;
   assign rsp_if.watch_running  = run_ff;
   assign rsp_if.key_rejected   = rejected_ff;

endmodule
